// ===== sv/protobuf_scalar_field_encoder_macros.svh =====
// Assertion macros for the protobuf scalar field encoder checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PROTOBUF_SCALAR_FIELD_ENCODER_MACROS_SVH
`define PROTOBUF_SCALAR_FIELD_ENCODER_MACROS_SVH

// Checked on every edge while reset is released.
`define PSFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PSFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/psfe_pkg.sv =====
// Shared types and constants for the protobuf scalar field encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psfe_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned SIZE_W  = 4;
    localparam int unsigned WT_W    = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned FIELD_W = 32;

    localparam logic [OP_W-1:0] OP_SVARINT = 3'd0;
    localparam logic [OP_W-1:0] OP_UVARINT = 3'd1;
    localparam logic [OP_W-1:0] OP_ZIGZAG  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIXED32 = 3'd3;
    localparam logic [OP_W-1:0] OP_FIXED64 = 3'd4;
    localparam logic [OP_W-1:0] OP_TAG     = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_1 = 4'd1;
    localparam logic [SIZE_W-1:0] SIZE_2 = 4'd2;
    localparam logic [SIZE_W-1:0] SIZE_4 = 4'd4;
    localparam logic [SIZE_W-1:0] SIZE_8 = 4'd8;

    localparam logic [CNT_W-1:0] FIXED32_BYTES = 4'd4;
    localparam logic [CNT_W-1:0] FIXED64_BYTES = 4'd8;

    localparam logic [BYTE_W-1:0] ERROR_BYTE = 8'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        logic               fixed;
        logic [CNT_W-1:0]   nbytes;
        logic               err;
    } load_t;

endpackage
`default_nettype wire

// ===== sv/psfe_format.sv =====
// Decodes one input item into the word to serialize and its encoding mode.
// Depends on psfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psfe_format
    import psfe_pkg::*;
(
    input  wire logic [OP_W-1:0]    op,
    input  wire logic [SIZE_W-1:0]  data_bytes,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [WT_W-1:0]    wire_type,
    output load_t                   load
);

    logic [VALUE_W-1:0] ext_word;
    logic               size_ok;
    logic               sign_ext;

    always_comb begin
        sign_ext = (op != OP_UVARINT);
        size_ok  = 1'b1;
        ext_word = value;
        unique case (data_bytes)
            SIZE_1: begin
                ext_word = {{(VALUE_W-8){sign_ext & value[7]}}, value[7:0]};
            end
            SIZE_2: begin
                ext_word = {{(VALUE_W-16){sign_ext & value[15]}}, value[15:0]};
            end
            SIZE_4: begin
                ext_word = {{(VALUE_W-32){sign_ext & value[31]}}, value[31:0]};
            end
            SIZE_8: begin
                ext_word = value;
            end
            default: begin
                size_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        load.word   = '0;
        load.fixed  = 1'b0;
        load.nbytes = '0;
        load.err    = 1'b0;
        unique case (op) inside
            OP_SVARINT, OP_UVARINT: begin
                load.word = ext_word;
                load.err  = !size_ok;
            end
            OP_ZIGZAG: begin
                load.word = {ext_word[VALUE_W-2:0], 1'b0} ^ {VALUE_W{ext_word[VALUE_W-1]}};
                load.err  = !size_ok;
            end
            OP_FIXED32: begin
                load.word   = {{(VALUE_W-32){1'b0}}, value[31:0]};
                load.fixed  = 1'b1;
                load.nbytes = FIXED32_BYTES;
            end
            OP_FIXED64: begin
                load.word   = value;
                load.fixed  = 1'b1;
                load.nbytes = FIXED64_BYTES;
            end
            OP_TAG: begin
                load.word = {{(VALUE_W-FIELD_W-WT_W){1'b0}}, value[FIELD_W-1:0], wire_type};
            end
            default: begin
                load.err = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/psfe_serializer.sv =====
// Shift register that sends the loaded word out one byte or 7-bit group per beat,
// with a registered output stage. Depends on psfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psfe_serializer
    import psfe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load_valid,
    input  wire load_t             load,
    output logic                   busy,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready
);

    logic               busy_reg, busy_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic               fixed_reg, fixed_next;
    logic               err_reg, err_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;
    logic               m_user_reg, m_user_next;

    logic               emit;
    logic [VALUE_W-1:0] rest;
    logic               last_c;
    logic [BYTE_W-1:0]  byte_c;

    assign emit = busy_reg && (!m_valid_reg || m_tready);
    assign rest = sh_reg >> GROUP_W;

    always_comb begin
        if (err_reg) begin
            last_c = 1'b1;
            byte_c = ERROR_BYTE;
        end else if (fixed_reg) begin
            last_c = (cnt_reg == CNT_W'(1));
            byte_c = sh_reg[BYTE_W-1:0];
        end else begin
            last_c = (rest == '0);
            byte_c = {!last_c, sh_reg[GROUP_W-1:0]};
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        sh_next      = sh_reg;
        fixed_next   = fixed_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = byte_c;
            m_last_next  = last_c;
            m_user_next  = err_reg;
            busy_next    = !last_c;
            sh_next      = fixed_reg ? (sh_reg >> BYTE_W) : rest;
            cnt_next     = cnt_reg - CNT_W'(1);
        end
        if (load_valid) begin
            busy_next  = 1'b1;
            sh_next    = load.word;
            fixed_next = load.fixed;
            err_next   = load.err;
            cnt_next   = load.nbytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg     <= sh_next;
        fixed_reg  <= fixed_next;
        err_reg    <= err_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign busy     = busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

// ===== sv/protobuf_scalar_field_encoder.sv =====
// Top level of the protobuf scalar field encoder.
// Depends on psfe_pkg, psfe_format and psfe_serializer.
//
// The s_ channel takes one scalar field per beat: the operation in s_tuser, the
// source size, value and wire type in s_tdata. The m_ channel returns the wire
// bytes of that field, one byte per beat in wire order, with m_tlast on the final
// byte and m_tuser set on the single zero byte returned for a bad size or op.
// An item is loaded into a 64-bit shift register on the beat it is accepted; the
// shift register then feeds the output register, one byte per cycle while m_tready
// is high. A negative signed varint is ten bytes long; the shift register is the
// limit.
// s_tready falls from acceptance until the final byte has entered the output
// register, so the next item can be taken while that byte still waits.
// When m_tready is low the output register holds its beat and the shift register
// waits. Synchronous reset drops s_tready's blocking state and m_tvalid at once.
`timescale 1ns / 1ps
`default_nettype none
module protobuf_scalar_field_encoder
    import psfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] data_bytes, [67:4] value, [70:68] wire_type, [71] zero
    input  wire logic [71:0] s_tdata,
    // [2:0] op
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // [0] error
    output logic             m_tuser
);

    load_t load;
    logic  busy;
    logic  accept;

    assign s_tready = !busy;
    assign accept   = s_tvalid && !busy;

    psfe_format u_format (
        .op         (s_tuser),
        .data_bytes (s_tdata[3:0]),
        .value      (s_tdata[67:4]),
        .wire_type  (s_tdata[70:68]),
        .load       (load)
    );

    psfe_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (accept),
        .load       (load),
        .busy       (busy),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready)
    );

endmodule
`default_nettype wire

// ===== sv/psfe_checker.sv =====
// Port-level checks for the protobuf scalar field encoder, bound to the top level.
// Depends on protobuf_scalar_field_encoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "protobuf_scalar_field_encoder_macros.svh"
module psfe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    `PSFE_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `PSFE_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")
    `PSFE_ASSERT(a_one_item_at_a_time, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
    `PSFE_ASSERT(a_error_beat_alone, m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00), "malformed error beat")

endmodule

bind protobuf_scalar_field_encoder psfe_checker u_psfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/protobuf_scalar_field_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for protobuf_scalar_field_encoder: random and directed fields in,
// predicted wire bytes compared beat by beat. Depends on psfe_pkg and the encoder RTL only.
module protobuf_scalar_field_encoder_tb;
    import psfe_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_PRINTS   = 20;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SIZE_W-1:0]  nbytes;
        logic [VALUE_W-1:0] value;
        logic [WT_W-1:0]    wt;
    } scalar_field_t;

    typedef struct packed {
        logic [BYTE_W-1:0] octet;
        logic              last;
        logic              err;
    } wire_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    scalar_field_t pending_fields[$];
    wire_beat_t    wire_bytes_q[$];
    scalar_field_t cur_field;
    wire_beat_t    want_beat;
    int            total_fields   = 1;
    int            fields_sent    = 0;
    int            mismatch_cnt   = 0;
    int            quiet_cycles   = 0;
    int            src_idle_pct;
    int            sink_stall_pct;

    protobuf_scalar_field_encoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTS) begin
            $display("[%0t] %s", $realtime, what);
        end
        mismatch_cnt++;
    endtask

    function automatic void push_beat(input logic [7:0] octet, input logic last,
                                      input logic err);
        wire_beat_t b;
        b.octet = octet;
        b.last  = last;
        b.err   = err;
        wire_bytes_q.push_back(b);
    endfunction

    function automatic void push_varint(input logic [63:0] v);
        int n;
        logic [6:0] grp;
        n = 0;
        do begin
            grp = v[6:0];
            v = v >> 7;
            push_beat({(v != 0), grp}, (v == 0), 1'b0);
            n++;
        end while (v != 0 && n < 10);
    endfunction

    function automatic bit widen(input logic [63:0] raw, input logic [3:0] nb,
                                 input bit sext, output logic [63:0] res);
        case (nb)
            SIZE_1: res = sext ? {{56{raw[7]}}, raw[7:0]} : {56'd0, raw[7:0]};
            SIZE_2: res = sext ? {{48{raw[15]}}, raw[15:0]} : {48'd0, raw[15:0]};
            SIZE_4: res = sext ? {{32{raw[31]}}, raw[31:0]} : {32'd0, raw[31:0]};
            SIZE_8: res = raw;
            default: begin
                res = '0;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void predict_wire_bytes(input scalar_field_t f);
        logic [63:0] v;
        int nfix;
        case (f.op) inside
            OP_SVARINT, OP_UVARINT, OP_ZIGZAG: begin
                if (!widen(f.value, f.nbytes, f.op != OP_UVARINT, v)) begin
                    push_beat(ERROR_BYTE, 1'b1, 1'b1);
                end else begin
                    if (f.op == OP_ZIGZAG) begin
                        v = (v << 1) ^ {64{v[63]}};
                    end
                    push_varint(v);
                end
            end
            OP_FIXED32, OP_FIXED64: begin
                nfix = (f.op == OP_FIXED32) ? int'(FIXED32_BYTES) : int'(FIXED64_BYTES);
                v = f.value;
                for (int i = 0; i < nfix; i++) begin
                    push_beat(v[7:0], i == nfix - 1, 1'b0);
                    v = v >> 8;
                end
            end
            OP_TAG: push_varint({29'd0, f.value[31:0], f.wt});
            default: push_beat(ERROR_BYTE, 1'b1, 1'b1);
        endcase
    endfunction

    task automatic add_field(input logic [2:0] op, input logic [3:0] nb,
                             input logic [63:0] value, input logic [2:0] wt);
        scalar_field_t f;
        f.op     = op;
        f.nbytes = nb;
        f.value  = value;
        f.wt     = wt;
        pending_fields.push_back(f);
    endtask

    // Sender and receiver idle rates follow the three stimulus phases.
    always_comb begin
        case (fields_sent * 3 / total_fields)
            0: begin
                src_idle_pct   = 7;
                sink_stall_pct = 45;
            end
            1: begin
                src_idle_pct   = 45;
                sink_stall_pct = 7;
            end
            default: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_wire_bytes(cur_field);
                fields_sent <= fields_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_fields.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_field = pending_fields.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_field.wt, cur_field.value, cur_field.nbytes};
                    s_tuser  <= cur_field.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (wire_bytes_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: byte %h last %b error %b",
                                          m_tdata, m_tlast, m_tuser));
            end else begin
                want_beat = wire_bytes_q.pop_front();
                if (m_tdata !== want_beat.octet) begin
                    report_mismatch($sformatf("byte %h, want %h", m_tdata, want_beat.octet));
                end
                if (m_tlast !== want_beat.last) begin
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want_beat.last));
                end
                if (m_tuser !== want_beat.err) begin
                    report_mismatch($sformatf("error %b, want %b", m_tuser, want_beat.err));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("protobuf_scalar_field_encoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] raw;
        logic [63:0] value;
        logic [2:0]  op;
        logic [3:0]  nb;

        // Zero values, widest encodings and sign boundaries per size.
        add_field(OP_SVARINT, SIZE_1, 64'h0, 3'd5);
        add_field(OP_SVARINT, SIZE_1, 64'hFFFF_FFFF_FFFF_FF80, 3'd0);
        add_field(OP_SVARINT, SIZE_2, 64'h0000_0000_0000_7FFF, 3'd7);
        add_field(OP_SVARINT, SIZE_4, 64'h1234_5678_8000_0000, 3'd0);
        add_field(OP_SVARINT, SIZE_8, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
        add_field(OP_SVARINT, SIZE_8, 64'h8000_0000_0000_0000, 3'd0);
        add_field(OP_UVARINT, SIZE_8, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
        add_field(OP_UVARINT, SIZE_1, 64'hAAAA_AAAA_AAAA_AAFF, 3'd0);
        add_field(OP_UVARINT, SIZE_2, 64'hFFFF_FFFF_FFFF_0000, 3'd0);
        add_field(OP_UVARINT, SIZE_4, 64'hDEAD_BEEF_FFFF_FFFF, 3'd0);
        add_field(OP_ZIGZAG, SIZE_1, 64'h0000_0000_0000_0080, 3'd0);
        add_field(OP_ZIGZAG, SIZE_2, 64'h0000_0000_0000_FFFF, 3'd0);
        add_field(OP_ZIGZAG, SIZE_8, 64'h7FFF_FFFF_FFFF_FFFF, 3'd0);
        add_field(OP_ZIGZAG, SIZE_8, 64'h8000_0000_0000_0000, 3'd0);
        add_field(OP_FIXED32, 4'd0, 64'hFFFF_FFFF_0102_0304, 3'd7);
        add_field(OP_FIXED64, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
        add_field(OP_FIXED64, SIZE_1, 64'h0, 3'd0);
        add_field(OP_TAG, 4'd0, 64'h0000_0000_FFFF_FFFF, 3'd7);
        add_field(OP_TAG, SIZE_8, 64'h0, 3'd0);
        add_field(OP_TAG, 4'd9, 64'hFFFF_FFFF_0000_0001, 3'd2);
        // Bad sizes and undefined operations.
        add_field(OP_SVARINT, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0);
        add_field(OP_UVARINT, 4'd15, 64'h1, 3'd0);
        add_field(OP_ZIGZAG, 4'd3, 64'h1, 3'd0);
        add_field(OP_RSVD_6, SIZE_8, 64'h1, 3'd1);
        add_field(OP_RSVD_7, SIZE_1, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            raw = {$urandom, $urandom};
            case ($urandom_range(3))
                0: value = raw;
                1: value = raw >> $urandom_range(63);
                2: value = ~(raw >> $urandom_range(63));
                default: value = raw >> (57 + $urandom_range(7));
            endcase
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(1) == 0) begin
                    op = $urandom_range(1) ? OP_RSVD_7 : OP_RSVD_6;
                    nb = SIZE_W'($urandom_range(15));
                end else begin
                    op = OP_W'($urandom_range(2));
                    nb = SIZE_W'($urandom_range(15));
                end
            end else begin
                op = OP_W'($urandom_range(5));
                case ($urandom_range(3))
                    0: nb = SIZE_1;
                    1: nb = SIZE_2;
                    2: nb = SIZE_4;
                    default: nb = SIZE_8;
                endcase
            end
            add_field(op, nb, value, WT_W'($urandom_range(7)));
        end
        total_fields = pending_fields.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_fields.size() != 0 || s_tvalid) @(posedge aclk);
        while (wire_bytes_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);

        if (wire_bytes_q.size() != 0) begin
            report_mismatch("expected bytes left over after drain");
        end
        if (mismatch_cnt == 0) begin
            $display("protobuf_scalar_field_encoder: match");
        end else begin
            $display("protobuf_scalar_field_encoder: mismatch");
        end
        $finish;
    end

endmodule
